>>> design/utla_pkg.sv
// ----------------------------------------------------------------------------
// utla_pkg
// shared types and constants of the universal test log accumulator
// ----------------------------------------------------------------------------
package utla_pkg;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_BLOCK_LENGTH = 1'b0,
		REG_STOP_BIT     = 1'b1
	} cfg_reg_t;

	localparam int BL_W      = 4;   // block length register width
	localparam int CNT_W     = 32;  // block and bit counters, stored indexes
	localparam int CFG_W     = 32;  // widest register
	localparam int SUM_W     = 48;  // log sum width
	localparam int LOGK_W    = 5;   // integer part of log2 of a 32-bit distance
	localparam int S_TDATA_W = 8;   // data_bit padded to a byte
	localparam int M_TDATA_W = 56;  // log_sum and block_done padded to bytes

	// blocks skipped before accumulation starts, times 2^L
	localparam logic [CNT_W-1:0] INIT_FACTOR = 32'd10;

	// reset values of the registers
	localparam logic [BL_W-1:0]  BLOCK_LENGTH_RST = 4'd6;
	localparam logic [CNT_W-1:0] STOP_BIT_RST     = 32'hFFFF_FFFF;

endpackage

>>> design/universal_test_log_accumulator_core.sv
// ----------------------------------------------------------------------------
// universal_test_log_accumulator_core
// log-distance accumulator of the universal randomness test
// ----------------------------------------------------------------------------
// Takes one bit per item on the slave side and returns one item per bit on the
// master side: the running log sum after that bit and a flag that the bit
// completed a block. Bits are packed msb-first into L-bit patterns
// (L = block_length, 0 acts as 1, values above MAX_BLOCK_LENGTH are clamped).
// On each completed block the last-seen block index of its pattern is read
// from an on-chip table and replaced by the current block index; after
// 10*2^L blocks and while the bit index is below stop_bit, log2 of the
// distance (FRAC_BITS fraction bits) is added to a 48-bit saturating sum.
// Throughput is one item per cycle, including back-to-back completed blocks
// at L = 1: the table is read and written at the same edge for the same
// pattern, so no forwarding is needed. From input accept to result an item
// passes table read, subtract, leading-one search, normalize, then one
// 32x32 squaring stage per fraction bit, then the saturating add into the
// output register. After reset the table is cleared one entry per cycle
// while s_tready stays low; configuration writes are taken at any time
// but are meant for idle periods. A stalled master side holds the whole
// pipeline.
// ----------------------------------------------------------------------------
module universal_test_log_accumulator_core #(
	parameter int MAX_BLOCK_LENGTH = 10,
	parameter int FRAC_BITS        = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  utla_pkg::cfg_reg_t        cfg_addr,
	input  logic [utla_pkg::CFG_W-1:0] cfg_wdata,
	// input bits
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [utla_pkg::S_TDATA_W-1:0] s_tdata,  // [0] data_bit, rest zero
	// results
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [utla_pkg::M_TDATA_W-1:0] m_tdata   // [47:0] log_sum, [48] block_done
);

	import utla_pkg::*;

	localparam int PW    = MAX_BLOCK_LENGTH;          // pattern width
	localparam int DEPTH = 1 << MAX_BLOCK_LENGTH;     // table entries
	localparam int LOG_W = LOGK_W + FRAC_BITS;        // fixed-point log2 width
	localparam logic [BL_W:0] MAXL = (BL_W+1)'(MAX_BLOCK_LENGTH);

	// configuration registers
	logic [BL_W-1:0]  block_length_q;
	logic [CNT_W-1:0] stop_bit_q;

	// front-end state
	logic [BL_W-1:0]  bit_in_block_q;
	logic [PW-1:0]    pattern_q;
	logic [CNT_W-1:0] block_count_q;
	logic [CNT_W-1:0] bit_index_q;

	// table clearing after reset
	logic             clr_active_q;
	logic [PW-1:0]    clr_addr_q;

	// last-seen block index per pattern
	logic [CNT_W-1:0] last_seen_mem [0:DEPTH-1];
	logic             mem_we;
	logic [PW-1:0]    mem_waddr;
	logic [CNT_W-1:0] mem_wdata;

	// handshake
	logic adv;       // whole pipeline moves
	logic accept;    // input item taken

	// front-end combinational
	logic [BL_W:0]    eff_len;
	logic [BL_W:0]    pos_inc;
	logic [BL_W:0]    shamt;
	logic [PW-1:0]    new_pat;
	logic             front_done;
	logic             front_add;
	logic [CNT_W-1:0] init_blocks;

	// stage 1: table read
	logic             valid_s1, done_s1, add_s1;
	logic [CNT_W-1:0] blk_s1, rd_s1;
	// stage 2: distance
	logic             valid_s2, done_s2, use_s2;
	logic [CNT_W-1:0] dist_s2;
	logic [CNT_W-1:0] dist_calc;
	// stage 3: leading one
	logic             valid_s3, done_s3, use_s3;
	logic [CNT_W-1:0] dist_s3;
	logic [LOGK_W-1:0] k_s3;
	logic [LOGK_W-1:0] k_calc;

	// squaring pipeline, index 0 is the normalized mantissa
	logic              sq_valid_s [0:FRAC_BITS];
	logic              sq_done_s  [0:FRAC_BITS];
	logic              sq_use_s   [0:FRAC_BITS];
	logic [LOGK_W-1:0] sq_k_s     [0:FRAC_BITS];
	logic [31:0]       sq_x_s     [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] sq_frac_s [0:FRAC_BITS];

	// accumulation and output
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	logic [SUM_W:0]   sum_wide;
	logic [LOG_W-1:0] log_val;
	logic             out_valid_q;
	logic             out_done_q;
	logic [SUM_W-1:0] out_sum_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv && !clr_active_q;
	assign accept   = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RST;
			stop_bit_q     <= STOP_BIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCK_LENGTH: block_length_q <= cfg_wdata[BL_W-1:0];
				REG_STOP_BIT:     stop_bit_q     <= cfg_wdata[CNT_W-1:0];
				default:          ;
			endcase
		end
	end

	// effective block length and bit packing, msb first
	always_comb begin
		if (block_length_q == '0)
			eff_len = (BL_W+1)'(1);
		else if ({1'b0, block_length_q} > MAXL)
			eff_len = MAXL;
		else
			eff_len = {1'b0, block_length_q};

		pos_inc = {1'b0, bit_in_block_q} + (BL_W+1)'(1);
		shamt   = eff_len - pos_inc;
		// bits at or beyond the block length are dropped
		if ({1'b0, bit_in_block_q} < eff_len)
			new_pat = pattern_q | (PW'(s_tdata[0]) << shamt);
		else
			new_pat = pattern_q;

		front_done  = pos_inc >= eff_len;
		init_blocks = INIT_FACTOR << eff_len;
		front_add   = (block_count_q >= init_blocks) && (bit_index_q < stop_bit_q);
	end

	// front-end counters and pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_in_block_q <= '0;
			pattern_q      <= '0;
			block_count_q  <= '0;
			bit_index_q    <= '0;
		end else if (accept) begin
			bit_index_q <= bit_index_q + CNT_W'(1);
			if (front_done) begin
				bit_in_block_q <= '0;
				pattern_q      <= '0;
				block_count_q  <= block_count_q + CNT_W'(1);
			end else begin
				bit_in_block_q <= pos_inc[BL_W-1:0];
				pattern_q      <= new_pat;
			end
		end
	end

	// clearing sweep over the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + PW'(1);
			if (clr_addr_q == '1)
				clr_active_q <= 1'b0;
		end
	end

	// table port: the read sees the old index, the write stores the current one
	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && front_done;
			mem_waddr = new_pat;
			mem_wdata = block_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			last_seen_mem[mem_waddr] <= mem_wdata;
		if (adv)
			rd_s1 <= last_seen_mem[new_pat];
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s1 <= front_done;
			add_s1  <= front_add;
			blk_s1  <= block_count_q;
		end
	end

	// stage 2: distance modulo 2^32, zero distance adds nothing
	assign dist_calc = blk_s1 - rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2 <= done_s1;
			use_s2  <= done_s1 && add_s1 && (dist_calc != '0);
			dist_s2 <= dist_calc;
		end
	end

	// stage 3: integer part of log2
	always_comb begin
		k_calc = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (dist_s2[i])
				k_calc = LOGK_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s3 <= done_s2;
			use_s3  <= use_s2;
			dist_s3 <= dist_s2;
			k_s3    <= k_calc;
		end
	end

	// stage 4: mantissa normalized to q1.31
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_valid_s[0] <= 1'b0;
		else if (adv)
			sq_valid_s[0] <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_done_s[0] <= done_s3;
			sq_use_s[0]  <= use_s3;
			sq_k_s[0]    <= k_s3;
			sq_x_s[0]    <= dist_s3 << (LOGK_W'(31) - k_s3);
			sq_frac_s[0] <= '0;
		end
	end

	// one squaring per fraction bit
	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
		logic [63:0] sq;
		logic        frac_bit;

		assign sq       = 64'(sq_x_s[j]) * 64'(sq_x_s[j]);
		assign frac_bit = sq[63];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_valid_s[j+1] <= 1'b0;
			else if (adv)
				sq_valid_s[j+1] <= sq_valid_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_done_s[j+1] <= sq_done_s[j];
				sq_use_s[j+1]  <= sq_use_s[j];
				sq_k_s[j+1]    <= sq_k_s[j];
				sq_x_s[j+1]    <= frac_bit ? sq[63:32] : sq[62:31];
				sq_frac_s[j+1] <= {sq_frac_s[j][FRAC_BITS-2:0], frac_bit};
			end
		end
	end

	// saturating accumulation
	assign log_val  = {sq_k_s[FRAC_BITS], sq_frac_s[FRAC_BITS]};
	assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(log_val);

	always_comb begin
		if (!sq_use_s[FRAC_BITS])
			sum_next = sum_q;
		else if (sum_wide[SUM_W])
			sum_next = '1;
		else
			sum_next = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq_valid_s[FRAC_BITS];
			if (sq_valid_s[FRAC_BITS])
				sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_sum_q  <= sum_next;
			out_done_q <= sq_done_s[FRAC_BITS];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W-SUM_W-1)'(0), out_done_q, out_sum_q};

`ifndef NO_ASSERTIONS
	// the running sum never goes down
	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> sum_q >= $past(sum_q))
		else $error("log sum decreased");

	// a result on the port always carries the current running sum
	a_out_matches_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_sum_q == sum_q)
		else $error("output sum out of step with accumulator");

	// a completed block restarts packing
	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && front_done |=> bit_in_block_q == '0 && pattern_q == '0)
		else $error("block state not cleared after completion");

	// the clearing sweep runs to the last entry without stopping
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q && (clr_addr_q != '1) |=> clr_active_q && !s_tready)
		else $error("table clearing ended early");
`endif

endmodule
